@@ rtl/core/kmtr_pkg.sv @@
package kmtr_pkg;

	localparam int DEPTH_COUNT_DEF = 64;
	localparam int LIST_SIZE_DEF = 256;

	localparam int DEPTH_W = 6;
	localparam int INDEX_W = 8;
	localparam int WORD_W = 32;
	localparam int PTR_W = 9;

	typedef enum logic [1:0] {
		CMD_LOAD    = 2'd0,
		CMD_SAVE    = 2'd1,
		CMD_REORDER = 2'd2,
		CMD_READ    = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t                      cmd;
		logic [DEPTH_W-1:0]        depth;
		logic [INDEX_W-1:0]        index;
		logic signed [WORD_W-1:0]  move_code;
		logic signed [WORD_W-1:0]  score_value;
		logic [PTR_W-1:0]          list_end;
	} in_item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0]  read_move;
		logic signed [WORD_W-1:0]  read_score;
		logic                      first_found;
		logic                      second_found;
	} out_item_t;

	typedef struct packed {
		logic capture;
		logic fetch;
		logic load_wr;
		logic save_wr;
		logic key_ld;
		logic scan;
		logic hit_ld;
		logic shift;
		logic out_ld;
		logic pass;
	} dp_ctl_t;

	typedef struct packed {
		cmd_t cmd;
		logic depth_ok;
		logic key_zero;
		logic hit;
		logic scan_empty;
		logic shift_last;
	} dp_stat_t;

endpackage

@@ rtl/core/kmtr_in_if.sv @@
interface kmtr_in_if;
	logic                                         valid;
	logic                                         ready;
	kmtr_pkg::cmd_t                               cmd;
	logic [kmtr_pkg::DEPTH_W-1:0]                 depth;
	logic [kmtr_pkg::INDEX_W-1:0]                 index;
	logic signed [kmtr_pkg::WORD_W-1:0]           move_code;
	logic signed [kmtr_pkg::WORD_W-1:0]           score_value;
	logic [kmtr_pkg::PTR_W-1:0]                   list_end;

	modport source (
		output valid, cmd, depth, index, move_code, score_value, list_end,
		input  ready
	);
	modport sink (
		input  valid, cmd, depth, index, move_code, score_value, list_end,
		output ready
	);
endinterface

@@ rtl/core/kmtr_out_if.sv @@
interface kmtr_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [kmtr_pkg::WORD_W-1:0]   read_move;
	logic signed [kmtr_pkg::WORD_W-1:0]   read_score;
	logic                                 first_found;
	logic                                 second_found;

	modport source (
		output valid, read_move, read_score, first_found, second_found,
		input  ready
	);
	modport sink (
		input  valid, read_move, read_score, first_found, second_found,
		output ready
	);
endinterface

@@ rtl/core/kmtr_dp.sv @@
module kmtr_dp #(
	parameter int DEPTH_COUNT = kmtr_pkg::DEPTH_COUNT_DEF,
	parameter int LIST_SIZE = kmtr_pkg::LIST_SIZE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  kmtr_pkg::in_item_t    item,
	input  kmtr_pkg::dp_ctl_t     ctl,
	output kmtr_pkg::dp_stat_t    stat,
	output kmtr_pkg::out_item_t   result
);

	localparam int DW = $clog2(DEPTH_COUNT);
	localparam int LW = $clog2(LIST_SIZE);
	localparam int PW = kmtr_pkg::PTR_W;
	localparam int WW = kmtr_pkg::WORD_W;

	kmtr_pkg::cmd_t                 cmd_q;
	logic [kmtr_pkg::DEPTH_W-1:0]   depth_q;
	logic [kmtr_pkg::INDEX_W-1:0]   index_q;
	logic [WW-1:0]                  move_q;
	logic [WW-1:0]                  score_q;
	logic [PW-1:0]                  end_q;

	logic [WW-1:0]                  kfirst_mem [DEPTH_COUNT];
	logic [WW-1:0]                  ksecond_mem [DEPTH_COUNT];
	logic [DEPTH_COUNT-1:0]         kvalid_q;
	logic [WW-1:0]                  kf_raw_q;
	logic [WW-1:0]                  ks_raw_q;
	logic                           kv_rd_q;

	logic [WW-1:0]                  move_mem [LIST_SIZE];
	logic [WW-1:0]                  score_mem [LIST_SIZE];
	logic [WW-1:0]                  rd_move_q;
	logic [WW-1:0]                  rd_score_q;

	logic [PW-1:0]                  ptr_q;
	logic [PW-1:0]                  start_q;
	logic [PW-1:0]                  j_q;
	logic [PW-1:0]                  addr_s1;
	logic                           rv_s1;
	logic [WW-1:0]                  key_q;
	logic [WW-1:0]                  carry_move_q;
	logic [WW-1:0]                  carry_score_q;
	logic                           f1_q;
	logic                           f2_q;

	logic [DW-1:0]                  kaddr;
	logic                           depth_ok;
	logic                           index_ok;
	logic [WW-1:0]                  kf;
	logic [WW-1:0]                  ks;
	logic                           save_take;
	logic                           scan_issue;
	logic                           shift_issue;
	logic                           rd_en;
	logic [LW-1:0]                  raddr;
	logic                           we;
	logic [LW-1:0]                  waddr;
	logic [WW-1:0]                  wmove;
	logic [WW-1:0]                  wscore;
	logic [PW-1:0]                  start_nx;

	assign kaddr = DW'(depth_q);
	assign depth_ok = PW'(depth_q) < PW'(DEPTH_COUNT);
	assign index_ok = PW'(index_q) < PW'(LIST_SIZE);
	assign kf = kv_rd_q ? kf_raw_q : '0;
	assign ks = kv_rd_q ? ks_raw_q : '0;
	assign save_take = index_ok && depth_ok && (kf != rd_move_q);

	assign scan_issue = ctl.scan && (ptr_q < end_q);
	assign shift_issue = ctl.shift && (ptr_q <= j_q);
	assign rd_en = ctl.fetch || scan_issue || shift_issue;
	assign raddr = ctl.fetch ? LW'(index_q) : ptr_q[LW-1:0];

	assign we = (ctl.load_wr && index_ok) || (ctl.shift && rv_s1);
	assign waddr = ctl.load_wr ? LW'(index_q) : addr_s1[LW-1:0];
	assign wmove = ctl.load_wr ? move_q : carry_move_q;
	assign wscore = ctl.load_wr ? score_q : carry_score_q;

	assign start_nx = ctl.pass ? PW'(index_q) + PW'(1) : PW'(index_q);

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q <= item.cmd;
			depth_q <= item.depth;
			index_q <= item.index;
			move_q <= item.move_code;
			score_q <= item.score_value;
			end_q <= (item.list_end < PW'(LIST_SIZE)) ? item.list_end : PW'(LIST_SIZE);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.save_wr && save_take) begin
			kfirst_mem[kaddr] <= rd_move_q;
			ksecond_mem[kaddr] <= kf;
		end
		if (ctl.fetch) begin
			kf_raw_q <= kfirst_mem[kaddr];
			ks_raw_q <= ksecond_mem[kaddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kvalid_q <= '0;
			kv_rd_q <= 1'b0;
		end else begin
			if (ctl.save_wr && save_take) begin
				kvalid_q[kaddr] <= 1'b1;
			end
			if (ctl.fetch) begin
				kv_rd_q <= kvalid_q[kaddr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			move_mem[waddr] <= wmove;
			score_mem[waddr] <= wscore;
		end
		if (rd_en) begin
			rd_move_q <= move_mem[raddr];
			rd_score_q <= score_mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1 <= 1'b0;
		end else if (ctl.key_ld || ctl.hit_ld) begin
			rv_s1 <= 1'b0;
		end else if (ctl.scan) begin
			rv_s1 <= scan_issue;
		end else if (ctl.shift) begin
			rv_s1 <= shift_issue;
		end else begin
			rv_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			f1_q <= 1'b0;
			f2_q <= 1'b0;
		end
		if (ctl.key_ld) begin
			key_q <= ctl.pass ? ks : kf;
			ptr_q <= start_nx;
			start_q <= start_nx;
		end else if (ctl.hit_ld) begin
			j_q <= addr_s1;
			carry_move_q <= rd_move_q;
			carry_score_q <= rd_score_q;
			ptr_q <= start_q;
			if (ctl.pass) begin
				f2_q <= 1'b1;
			end else begin
				f1_q <= 1'b1;
			end
		end else if (ctl.scan) begin
			addr_s1 <= ptr_q;
			if (scan_issue) begin
				ptr_q <= ptr_q + PW'(1);
			end
		end else if (ctl.shift) begin
			addr_s1 <= ptr_q;
			if (shift_issue) begin
				ptr_q <= ptr_q + PW'(1);
			end
			if (rv_s1) begin
				carry_move_q <= rd_move_q;
				carry_score_q <= rd_score_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_ld) begin
			if (cmd_q == kmtr_pkg::CMD_READ && index_ok) begin
				result.read_move <= rd_move_q;
				result.read_score <= rd_score_q;
			end else begin
				result.read_move <= '0;
				result.read_score <= '0;
			end
			result.first_found <= f1_q;
			result.second_found <= f2_q;
		end
	end

	always_comb begin
		stat.cmd = cmd_q;
		stat.depth_ok = depth_ok;
		stat.key_zero = (key_q == '0);
		stat.hit = rv_s1 && (rd_move_q == key_q);
		stat.scan_empty = !rv_s1 && !(ptr_q < end_q);
		stat.shift_last = rv_s1 && (addr_s1 == j_q);
	end

endmodule

@@ rtl/core/kmtr_ctrl.sv @@
module kmtr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  kmtr_pkg::dp_stat_t   stat,
	output kmtr_pkg::dp_ctl_t    dp_ctl
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_FETCH = 7'b0000010,
		S_SAVE  = 7'b0000100,
		S_KEY   = 7'b0001000,
		S_SCAN  = 7'b0010000,
		S_SHIFT = 7'b0100000,
		S_RESP  = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   pass_q;
	logic   pass_nx;
	logic   out_valid_q;
	logic   advance;

	always_comb begin
		state_nx = state_q;
		pass_nx = pass_q;
		in_ready = 1'b0;
		advance = 1'b0;
		dp_ctl = '0;
		dp_ctl.pass = pass_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					dp_ctl.capture = 1'b1;
					pass_nx = 1'b0;
					state_nx = S_FETCH;
				end
			end
			S_FETCH: begin
				dp_ctl.fetch = 1'b1;
				unique case (stat.cmd)
					kmtr_pkg::CMD_LOAD: begin
						dp_ctl.load_wr = 1'b1;
						state_nx = S_RESP;
					end
					kmtr_pkg::CMD_SAVE: state_nx = S_SAVE;
					kmtr_pkg::CMD_REORDER: state_nx = S_KEY;
					kmtr_pkg::CMD_READ: state_nx = S_RESP;
					default: state_nx = S_RESP;
				endcase
			end
			S_SAVE: begin
				dp_ctl.save_wr = 1'b1;
				state_nx = S_RESP;
			end
			S_KEY: begin
				dp_ctl.key_ld = 1'b1;
				state_nx = stat.depth_ok ? S_SCAN : S_RESP;
			end
			S_SCAN: begin
				dp_ctl.scan = 1'b1;
				if (stat.key_zero) begin
					advance = 1'b1;
				end else if (stat.hit) begin
					dp_ctl.hit_ld = 1'b1;
					state_nx = S_SHIFT;
				end else if (stat.scan_empty) begin
					advance = 1'b1;
				end
			end
			S_SHIFT: begin
				dp_ctl.shift = 1'b1;
				if (stat.shift_last) begin
					advance = 1'b1;
				end
			end
			S_RESP: begin
				if (!out_valid_q || out_ready) begin
					dp_ctl.out_ld = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
		if (advance) begin
			if (pass_q) begin
				state_nx = S_RESP;
			end else begin
				pass_nx = 1'b1;
				state_nx = S_KEY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pass_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			pass_q <= pass_nx;
			if (dp_ctl.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_accept_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_FETCH))
		else $error("accepted transaction did not start a fetch");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		dp_ctl.out_ld |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken transaction");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		dp_ctl.out_ld |=> out_valid_q)
		else $error("loaded result not presented");

	a_pass_reorder: assert property (@(posedge clk) disable iff (!arst_n)
		pass_q |-> (stat.cmd == kmtr_pkg::CMD_REORDER))
		else $error("second pass outside a reorder");

	a_hit_key: assert property (@(posedge clk) disable iff (!arst_n)
		dp_ctl.hit_ld |-> !stat.key_zero)
		else $error("zero killer matched");

endmodule

@@ rtl/core/killer_move_table_reorder.sv @@
// Load and read go from a fetch state to the response state; save passes a save state in between.
// In a reorder, each killer in turn is searched for in the list and then
// rotated into place, one list entry per cycle through the single list read port.
// A new transaction is accepted once the previous result sits in the output register.
// Reset clears control state and marks every killer slot empty so it reads as zero;
// the list store holds no defined value until it is loaded.
module killer_move_table_reorder #(
	parameter int DEPTH_COUNT = kmtr_pkg::DEPTH_COUNT_DEF,
	parameter int LIST_SIZE = kmtr_pkg::LIST_SIZE_DEF
) (
	input logic         clk,
	input logic         arst_n,
	kmtr_in_if.sink     in_ch,
	kmtr_out_if.source  out_ch
);

	kmtr_pkg::in_item_t   item;
	kmtr_pkg::out_item_t  result;
	kmtr_pkg::dp_ctl_t    dp_ctl;
	kmtr_pkg::dp_stat_t   stat;

	always_comb begin
		item.cmd = in_ch.cmd;
		item.depth = in_ch.depth;
		item.index = in_ch.index;
		item.move_code = in_ch.move_code;
		item.score_value = in_ch.score_value;
		item.list_end = in_ch.list_end;
	end

	kmtr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.dp_ctl    (dp_ctl)
	);

	kmtr_dp #(
		.DEPTH_COUNT (DEPTH_COUNT),
		.LIST_SIZE   (LIST_SIZE)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.ctl    (dp_ctl),
		.stat   (stat),
		.result (result)
	);

	assign out_ch.read_move = result.read_move;
	assign out_ch.read_score = result.read_score;
	assign out_ch.first_found = result.first_found;
	assign out_ch.second_found = result.second_found;

endmodule
